[rtl/lbut_pkg.sv]
// Shared types and constants for the LED blink and uptime timer.
`default_nettype none

package lbut_pkg;

    // Default channel count and tick rate.
    localparam int NUM_CHANNELS_DEF     = 3;
    localparam int TICKS_PER_SECOND_DEF = 10;

    // Fixed field widths.
    localparam int CFG_DATA_W = 8;
    localparam int TIME_W     = 32;

    // Transaction command codes.
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

[rtl/led_blink_uptime_timer_unit.sv]
// Top level of the LED blink and uptime timer.
`default_nettype none

// Each input transaction is either a tick (one tenth of a second by default)
// or a load of the POSIX seconds counter. A tick advances every blink
// channel: a channel is lit while its count is below its duty setting, and
// the count wraps to zero on reaching its cycle setting (a cycle of zero
// holds the count at zero). Every TICKS_PER_SECOND ticks the uptime and
// POSIX counters advance by one, wrapping at 32 bits. Each transaction
// produces exactly one result, registered in the cycle after acceptance, and a new
// transaction can be accepted every clock, limited only by the single
// result register that holds a result until the downstream side takes it.
// Writing a channel's cycle or duty register clears that channel's count;
// configuration is written by the user only while no result is pending;
// the block does not enforce it. Indexes past the last channel are ignored.
module led_blink_uptime_timer_unit #(
    parameter int NUM_CHANNELS     = lbut_pkg::NUM_CHANNELS_DEF,
    parameter int TICKS_PER_SECOND = lbut_pkg::TICKS_PER_SECOND_DEF,
    parameter int CFG_IDX_W        = $clog2(2 * NUM_CHANNELS)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [lbut_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [lbut_pkg::TIME_W-1:0]   s_time_value,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [NUM_CHANNELS-1:0]            m_led_levels,
    output logic [NUM_CHANNELS-1:0]            m_led_changed,
    output logic                               m_second_elapsed,
    output logic [lbut_pkg::TIME_W-1:0]        m_uptime_seconds,
    output logic [lbut_pkg::TIME_W-1:0]        m_posix_seconds
);
    import lbut_pkg::*;

    localparam int PRESCALE_W = $clog2(TICKS_PER_SECOND + 1);
    localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(TICKS_PER_SECOND - 1);

    logic [CFG_DATA_W-1:0]  cycle_reg  [NUM_CHANNELS];
    logic [CFG_DATA_W-1:0]  duty_reg   [NUM_CHANNELS];
    logic [CFG_DATA_W-1:0]  count_reg  [NUM_CHANNELS];
    logic [CFG_DATA_W-1:0]  count_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] level_reg;
    logic [NUM_CHANNELS-1:0] level_next;
    logic [NUM_CHANNELS-1:0] changed_reg;
    logic [NUM_CHANNELS-1:0] changed_next;
    logic [PRESCALE_W-1:0]  prescale_reg;
    logic [PRESCALE_W-1:0]  prescale_next;
    logic                   sec_reg;
    logic                   sec_next;
    logic [TIME_W-1:0]      uptime_reg;
    logic [TIME_W-1:0]      uptime_next;
    logic [TIME_W-1:0]      posix_reg;
    logic [TIME_W-1:0]      posix_next;
    logic                   m_valid_reg;
    logic                   in_fire;
    logic                   tick_fire;
    logic                   load_fire;

    // The result register frees up when empty or when its result is taken.
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign tick_fire = in_fire && (cmd_t'(s_cmd) == CMD_TICK);
    assign load_fire = in_fire && (cmd_t'(s_cmd) == CMD_LOAD);

    // Per-channel blink step: level from count against duty, then count wraps.
    always_comb begin
        logic [CFG_DATA_W:0] inc;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            inc           = {1'b0, count_reg[i]} + (CFG_DATA_W+1)'(1);
            level_next[i] = count_reg[i] < duty_reg[i];
            count_next[i] = (inc >= {1'b0, cycle_reg[i]}) ? '0 : inc[CFG_DATA_W-1:0];
        end
        changed_next = level_next ^ level_reg;
    end

    // Seconds prescaler and the two seconds counters.
    always_comb begin
        logic [PRESCALE_W:0] pre_inc;
        pre_inc       = {1'b0, prescale_reg} + (PRESCALE_W+1)'(1);
        sec_next      = pre_inc >= (PRESCALE_W+1)'(TICKS_PER_SECOND);
        prescale_next = sec_next ? '0 : pre_inc[PRESCALE_W-1:0];
        uptime_next   = uptime_reg + TIME_W'(sec_next);
        posix_next    = posix_reg + TIME_W'(sec_next);
    end

    // Configuration registers and blink counts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                cycle_reg[i] <= '0;
                duty_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            level_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (cfg_wr_en && cfg_index == CFG_IDX_W'(2 * i)) begin
                    cycle_reg[i] <= cfg_wdata;
                    count_reg[i] <= '0;
                end else if (cfg_wr_en && cfg_index == CFG_IDX_W'(2 * i + 1)) begin
                    duty_reg[i]  <= cfg_wdata;
                    count_reg[i] <= '0;
                end else if (tick_fire) begin
                    count_reg[i] <= count_next[i];
                end
            end
            if (tick_fire) begin
                level_reg <= level_next;
            end
        end
    end

    // Time counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            uptime_reg   <= '0;
            posix_reg    <= '0;
        end else if (tick_fire) begin
            prescale_reg <= prescale_next;
            uptime_reg   <= uptime_next;
            posix_reg    <= posix_next;
        end else if (load_fire) begin
            posix_reg    <= s_time_value;
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Per-transaction event flags; a load reports no change and no second.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            changed_reg <= tick_fire ? changed_next : '0;
            sec_reg     <= tick_fire && sec_next;
        end
    end

    // The state registers hold still while a result waits, so they double as
    // the result payload.
    assign m_valid          = m_valid_reg;
    assign m_led_levels     = level_reg;
    assign m_led_changed    = changed_reg;
    assign m_second_elapsed = sec_reg;
    assign m_uptime_seconds = uptime_reg;
    assign m_posix_seconds  = posix_reg;

    // The prescaler never reaches the tick rate.
    a_prescale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        prescale_reg <= PRESCALE_LAST)
        else $error("prescaler out of range");

    // A reported second always leaves the prescaler at zero.
    a_sec_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_second_elapsed |-> prescale_reg == '0)
        else $error("second reported without prescaler wrap");

    // A load produces no level change and no second.
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && load_fire |=> m_led_changed == '0 && !m_second_elapsed)
        else $error("load reported an event");

    // The last tick of a second advances the uptime by one.
    a_uptime_step: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && tick_fire && prescale_reg == PRESCALE_LAST
        |=> uptime_reg == $past(uptime_reg) + TIME_W'(1))
        else $error("uptime did not advance");

    // Levels only move on a tick transaction.
    a_level_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !tick_fire |=> $stable(level_reg))
        else $error("levels changed without a tick");

endmodule

`default_nettype wire
